// ----- hw/rtl/mbr_pkg.sv -----
// Package: shared constants, codes and item types of the MSB-first bit reader.
package mbr_pkg;

  localparam int unsigned ReservoirBits = 64;
  localparam int unsigned HeldW         = $clog2(ReservoirBits + 1);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic       ActPush = 1'b0;
  localparam logic       ActRead = 1'b1;

  localparam logic [5:0] MaxReadBits = 6'd32;

  typedef enum logic [1:0] {
    SWAP_NONE = 2'd0,
    SWAP_16   = 2'd1,
    SWAP_32   = 2'd2
  } swap_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic       is_read;
    logic [7:0] byte_in;
    logic [5:0] bit_count;
    swap_e      swap;
  } op_t;

endpackage

// ----- hw/rtl/mbr_in_if.sv -----
// Interface: input item channel of the bit reader.
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_in;
  logic [5:0] bit_count;
  logic [1:0] swap_mode;

  modport source (output valid, action, byte_in, bit_count, swap_mode, input ready);
  modport sink   (input valid, action, byte_in, bit_count, swap_mode, output ready);
endinterface

// ----- hw/rtl/mbr_out_if.sv -----
// Interface: result item channel of the bit reader.
interface mbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic [6:0]  bits_left;

  modport source (output valid, value, status, bits_left, input ready);
  modport sink   (input valid, value, status, bits_left, output ready);
endinterface

// ----- hw/rtl/mbr_front.sv -----
// Front end: accepts input items and classifies them into queued operations.
module mbr_front (
  mbr_in_if.sink       in_i,
  output logic         op_valid_o,
  output mbr_pkg::op_t op_o,
  input  logic         op_ready_i
);

  always_comb begin
    op_o.is_read = (in_i.action == mbr_pkg::ActRead);
    op_o.byte_in = in_i.byte_in;
    if (in_i.bit_count > mbr_pkg::MaxReadBits) begin
      op_o.bit_count = mbr_pkg::MaxReadBits;
    end else begin
      op_o.bit_count = in_i.bit_count;
    end
    unique case (in_i.swap_mode)
      mbr_pkg::SWAP_16: op_o.swap = mbr_pkg::SWAP_16;
      mbr_pkg::SWAP_32: op_o.swap = mbr_pkg::SWAP_32;
      default:          op_o.swap = mbr_pkg::SWAP_NONE;
    endcase
  end

  assign op_valid_o = in_i.valid;
  assign in_i.ready = op_ready_i;

endmodule

// ----- hw/rtl/mbr_queue.sv -----
// Queue: short FIFO of classified operations between front and back end.
module mbr_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  input  mbr_pkg::op_t wr_op_i,
  output logic         wr_ready_o,
  output logic         rd_valid_o,
  output mbr_pkg::op_t rd_op_o,
  input  logic         rd_ready_i
);

  mbr_pkg::op_t                     mem_q [mbr_pkg::QueueDepth];
  logic [mbr_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mbr_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mbr_pkg::QueueCntW-1:0]    count_q, count_d;
  logic                             wr_fire, rd_fire;

  localparam logic [mbr_pkg::QueuePtrW-1:0] LastPtr =
    mbr_pkg::QueuePtrW'(mbr_pkg::QueueDepth - 1);
  localparam logic [mbr_pkg::QueueCntW-1:0] FullCnt =
    mbr_pkg::QueueCntW'(mbr_pkg::QueueDepth);

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  assign rd_op_o    = mem_q[rd_ptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_fire, rd_fire})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

// ----- hw/rtl/mbr_back.sv -----
// Back end: reservoir, barrel-shift extraction, byte swap and result register.
module mbr_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  mbr_pkg::op_t op_i,
  output logic         op_ready_o,
  mbr_out_if.source    out_o
);

  localparam int unsigned ResBits = mbr_pkg::ReservoirBits;
  localparam int unsigned HeldW   = mbr_pkg::HeldW;
  localparam logic [HeldW-1:0] PushLimit = HeldW'(ResBits - 8);
  localparam logic [HeldW-1:0] ByteBits  = HeldW'(8);

  logic [ResBits-1:0] res_q, res_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic               out_valid_q;
  logic [31:0]        value_q, value_d;
  mbr_pkg::status_e   status_q, status_d;
  logic [6:0]         left_q;
  logic               fire;
  logic [HeldW-1:0]   cnt;
  logic [HeldW-1:0]   pos;
  logic [ResBits-1:0] shifted;
  logic [31:0]        raw;
  logic [HeldW+6:0]   held_wide;

  assign op_ready_o = !out_valid_q || out_o.ready;
  assign fire       = op_valid_i && op_ready_o;

  assign cnt     = HeldW'(op_i.bit_count);
  assign pos     = held_q - cnt;
  assign shifted = res_q >> pos;
  assign raw     = shifted[31:0] & ~(32'hFFFF_FFFF << op_i.bit_count);

  always_comb begin
    res_d    = res_q;
    held_d   = held_q;
    value_d  = '0;
    status_d = mbr_pkg::STATUS_OK;
    if (!op_i.is_read) begin
      if (held_q > PushLimit) begin
        status_d = mbr_pkg::STATUS_OVERFLOW;
      end else begin
        res_d  = {res_q[ResBits-9:0], op_i.byte_in};
        held_d = held_q + ByteBits;
      end
    end else if (cnt > held_q) begin
      status_d = mbr_pkg::STATUS_UNDERFLOW;
    end else begin
      held_d = pos;
      unique case (op_i.swap)
        mbr_pkg::SWAP_16: value_d = {16'h0000, raw[7:0], raw[15:8]};
        mbr_pkg::SWAP_32: value_d = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
        default:          value_d = raw;
      endcase
    end
  end

  assign held_wide = {7'd0, held_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        res_q  <= res_d;
        held_q <= held_d;
      end
      if (op_ready_o) begin
        out_valid_q <= op_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q  <= value_d;
      status_q <= status_d;
      left_q   <= held_wide[6:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = value_q;
  assign out_o.status    = status_q;
  assign out_o.bits_left = left_q;

endmodule

// ----- hw/rtl/msb_first_bit_reader.sv -----
// Top level: MSB-first bit reader with byte push and 0..32 bit reads.
// Accepts one push or read item every clock cycle while results are taken and
// returns one result item for each, in order; each item is written into the queue,
// read by the back end and held in its output register until the result is taken.
// The front end classifies items into a two-entry queue; the back end updates the
// 64-bit reservoir with a single barrel shift per item and holds the result in an
// output register, so input is taken while a finished result waits to be taken,
// until the two queue entries fill.
module msb_first_bit_reader (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbr_in_if.sink     in_i,
  mbr_out_if.source  out_o
);

  logic         f_valid, f_ready;
  mbr_pkg::op_t f_op;
  logic         b_valid, b_ready;
  mbr_pkg::op_t b_op;

  mbr_front u_front (
    .in_i       (in_i),
    .op_valid_o (f_valid),
    .op_o       (f_op),
    .op_ready_i (f_ready)
  );

  mbr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_op_i    (f_op),
    .wr_ready_o (f_ready),
    .rd_valid_o (b_valid),
    .rd_op_o    (b_op),
    .rd_ready_i (b_ready)
  );

  mbr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (b_valid),
    .op_i       (b_op),
    .op_ready_o (b_ready),
    .out_o      (out_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench: directed and random push/read items against a bit reservoir predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MaxItems    = 2048;
  localparam int unsigned RandomItems = 1650;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned LongHold    = 120;
  localparam logic [1:0]  SwapUnused  = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_in;
    logic [5:0] bit_count;
    logic [1:0] swap_mode;
    logic       drain_first;
  } bit_op_t;

  typedef struct packed {
    logic [31:0]       value;
    mbr_pkg::status_e  status;
    logic [6:0]        bits_left;
  } read_result_t;

  logic clk_i;
  logic rst_ni;

  mbr_in_if  in_if ();
  mbr_out_if out_if ();

  msb_first_bit_reader uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit_op_t      pending_ops[$];
  bit_op_t      current_op;
  read_result_t predicted_results[MaxItems];
  logic [63:0]  model_bits;
  int unsigned  model_held;
  int unsigned  items_in;
  int unsigned  results_out;
  int unsigned  total_items;
  int unsigned  send_gap;
  int unsigned  take_gap;
  int unsigned  hold_off;
  int unsigned  idle_cycles;
  int unsigned  errors;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned idx,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %h, want %h", what, idx, got, want);
    errors++;
  endtask

  function automatic read_result_t reservoir_step(input bit_op_t op);
    read_result_t r;
    int unsigned  take;
    logic [63:0]  word;
    logic [31:0]  bits;
    r.value  = 32'd0;
    r.status = mbr_pkg::STATUS_OK;
    if (op.action == mbr_pkg::ActPush) begin
      if (model_held + 8 > mbr_pkg::ReservoirBits) begin
        r.status = mbr_pkg::STATUS_OVERFLOW;
      end else begin
        model_bits = {model_bits[55:0], op.byte_in};
        model_held += 8;
      end
    end else begin
      take = (op.bit_count > mbr_pkg::MaxReadBits) ? int'(mbr_pkg::MaxReadBits)
                                                   : int'(op.bit_count);
      if (take > model_held) begin
        r.status = mbr_pkg::STATUS_UNDERFLOW;
      end else begin
        word = (model_bits >> (model_held - take)) & ((64'd1 << take) - 64'd1);
        bits = word[31:0];
        model_held -= take;
        case (op.swap_mode)
          mbr_pkg::SWAP_16: begin
            bits = {16'd0, bits[7:0], bits[15:8]};
          end
          mbr_pkg::SWAP_32: begin
            bits = {bits[7:0], bits[15:8], bits[23:16], bits[31:24]};
          end
          default: begin
          end
        endcase
        r.value = bits;
      end
    end
    r.bits_left = 7'(model_held);
    return r;
  endfunction

  task automatic queue_op(input logic action, input logic [7:0] byte_in,
                          input logic [5:0] bit_count, input logic [1:0] swap_mode,
                          input logic drain_first);
    bit_op_t op;
    op.action      = action;
    op.byte_in     = byte_in;
    op.bit_count   = bit_count;
    op.swap_mode   = swap_mode;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic accepted;
    if (rst_ni) begin
      accepted = in_if.valid && in_if.ready;
      if (accepted) begin
        predicted_results[items_in] = reservoir_step(current_op);
        items_in <= items_in + 1;
        send_gap = ((items_in / 128) % 3 == 1) ? 0 : $urandom_range(0, 13);
      end
      if (in_if.valid && !in_if.ready) begin
      end else if (send_gap != 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   (!pending_ops[0].drain_first || (!accepted && results_out == items_in))) begin
        current_op = pending_ops.pop_front();
        in_if.action    <= current_op.action;
        in_if.byte_in   <= current_op.byte_in;
        in_if.bit_count <= current_op.bit_count;
        in_if.swap_mode <= current_op.swap_mode;
        in_if.valid     <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    read_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (results_out >= items_in) begin
          report_mismatch("unexpected result", results_out, out_if.value, 32'd0);
        end else begin
          want = predicted_results[results_out];
          if (out_if.value !== want.value)
            report_mismatch("value", results_out, out_if.value, want.value);
          if (out_if.status !== want.status)
            report_mismatch("status", results_out, {30'd0, out_if.status}, {30'd0, want.status});
          if (out_if.bits_left !== want.bits_left)
            report_mismatch("bits_left", results_out, {25'd0, out_if.bits_left},
                            {25'd0, want.bits_left});
          results_out <= results_out + 1;
        end
        if (results_out == 300 || results_out == 1200) begin
          hold_off = LongHold;
        end else begin
          take_gap = ((results_out / 100) % 3 == 2) ? 0 : $urandom_range(0, 13);
        end
      end
      if (hold_off != 0) begin
        hold_off--;
        out_if.ready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("msb_first_bit_reader test failed");
        $finish;
      end
    end
  end

  initial begin
    bit_op_t     op;
    int unsigned gen_held;
    int unsigned push_pct;
    int unsigned take;
    int unsigned limit;
    logic [31:0] rnd;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = mbr_pkg::ActPush;
    in_if.byte_in    = 8'd0;
    in_if.bit_count  = 6'd0;
    in_if.swap_mode  = mbr_pkg::SWAP_NONE;
    out_if.ready     = 1'b0;
    model_bits       = 64'd0;
    model_held       = 0;
    items_in         = 0;
    results_out      = 0;
    send_gap         = 0;
    take_gap         = 0;
    hold_off         = 0;
    idle_cycles      = 0;
    errors           = 0;

    queue_op(mbr_pkg::ActRead, 8'h00, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'hff, 6'd1,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd63, mbr_pkg::SWAP_32,   1'b0);
    queue_op(mbr_pkg::ActPush, 8'hff, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h00, 6'd63, mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'ha5, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h5a, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd32, mbr_pkg::SWAP_32,   1'b0);
    queue_op(mbr_pkg::ActPush, 8'h01, 6'd0,  mbr_pkg::SWAP_NONE, 1'b1);
    queue_op(mbr_pkg::ActPush, 8'h23, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h45, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h67, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h89, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'hab, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'hcd, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'hef, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'hff, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'hff, 6'd63, mbr_pkg::SWAP_16,   1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd3,  SwapUnused,         1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd0,  mbr_pkg::SWAP_32,   1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd33, mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd29, mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActPush, 8'h80, 6'd0,  mbr_pkg::SWAP_NONE, 1'b0);
    queue_op(mbr_pkg::ActRead, 8'h00, 6'd8,  mbr_pkg::SWAP_16,   1'b0);

    // keep the reservoir mostly in range, with some overflow and underflow noise
    gen_held = 0;
    for (int n = 0; n < RandomItems; n++) begin
      rnd            = $urandom;
      op.byte_in     = rnd[7:0];
      op.bit_count   = rnd[13:8];
      op.swap_mode   = rnd[15:14];
      op.drain_first = (n == 500) || ($urandom_range(0, 199) == 0);
      push_pct = (gen_held < 24) ? 75 : ((gen_held > 56) ? 30 : 50);
      op.action = ($urandom_range(0, 99) < push_pct) ? mbr_pkg::ActPush : mbr_pkg::ActRead;
      if (op.action == mbr_pkg::ActRead && $urandom_range(0, 9) != 0) begin
        limit = (gen_held < 32) ? gen_held : 32;
        op.bit_count = 6'($urandom_range(0, limit));
      end
      if (op.action == mbr_pkg::ActPush) begin
        if (gen_held + 8 <= mbr_pkg::ReservoirBits) gen_held += 8;
      end else begin
        take = (op.bit_count > mbr_pkg::MaxReadBits) ? 32 : int'(op.bit_count);
        if (take <= gen_held) gen_held -= take;
      end
      pending_ops.push_back(op);
    end
    total_items = pending_ops.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_in != total_items || results_out != items_in) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (results_out != items_in)
      report_mismatch("missing results", results_out, results_out, items_in);

    if (errors == 0) begin
      $display("msb_first_bit_reader test passed");
    end else begin
      $display("msb_first_bit_reader test failed");
    end
    $finish;
  end

endmodule

// ----- msb_first_bit_reader.f -----
hw/rtl/mbr_pkg.sv
hw/rtl/mbr_in_if.sv
hw/rtl/mbr_out_if.sv
hw/rtl/mbr_front.sv
hw/rtl/mbr_queue.sv
hw/rtl/mbr_back.sv
hw/rtl/msb_first_bit_reader.sv
tb/sv/testbench.sv
